>>> src/binary_max_heap_queue_top_assert.svh
// Assertion macros used by the binary max-heap queue datapath.
`ifndef BINARY_MAX_HEAP_QUEUE_TOP_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMHQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("binary max-heap queue assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("binary max-heap queue assertion failed");

`endif

>>> src/bmhq_pkg.sv
// Shared constants, types and codes of the binary max-heap queue.
package bmhq_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW          = $clog2(DEPTH + 1);
    localparam int IW          = CW + 1;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [CW-1:0]                 t_count;
    typedef logic [AW-1:0]                 t_addr;
    typedef logic [IW-1:0]                 t_index;

    localparam logic       CMD_PUSH = 1'b0;
    localparam logic       CMD_POP  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic load_push;
        logic load_pop;
        logic refuse_full;
        logic refuse_empty;
        logic rd_parent;
        logic rd_children;
        logic take_last;
        logic move_up;
        logic move_down;
        logic place;
    } t_dp_cmd;

    typedef struct packed {
        logic hole_root;
        logic has_child;
        logic parent_less;
        logic child_greater;
        logic full;
        logic empty;
    } t_dp_sts;

endpackage

>>> src/bmhq_dp.sv
// Datapath of the binary max-heap queue: heap memory, hole pointer and result registers.
`include "binary_max_heap_queue_top_assert.svh"

module bmhq_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmhq_pkg::t_value  i_value,
    input  bmhq_pkg::t_dp_cmd i_dp_cmd,
    output bmhq_pkg::t_dp_sts o_dp_sts,
    output bmhq_pkg::t_value  o_top_value,
    output bmhq_pkg::t_value  o_removed_value,
    output bmhq_pkg::t_count  o_entry_count,
    output logic              o_is_empty,
    output logic [1:0]        o_status
);
    import bmhq_pkg::*;

    t_value     r_mem [DEPTH];
    t_value     r_rd_a;
    t_value     r_rd_b;
    t_value     r_val;
    t_value     r_top;
    t_value     r_removed;
    t_count     r_count;
    t_addr      r_hole;
    logic [1:0] r_status;

    t_addr      parent_addr;
    t_index     left_idx;
    t_index     right_idx;
    t_index     count_idx;
    logic       use_right;
    t_value     sel_val;
    t_index     sel_idx;
    t_addr      rd_addr_a;
    t_addr      rd_addr_b;
    logic       rd_en;
    logic       wr_en;
    t_value     wr_data;

    always_comb begin
        parent_addr = (r_hole - AW'(1)) >> 1;
        left_idx    = IW'({r_hole, 1'b1});
        right_idx   = left_idx + IW'(1);
        count_idx   = IW'(r_count);
        use_right   = (right_idx < count_idx) && (r_rd_a < r_rd_b);
        sel_val     = use_right ? r_rd_b : r_rd_a;
        sel_idx     = use_right ? right_idx : left_idx;

        if (i_dp_cmd.load_pop) begin
            rd_addr_a = AW'(r_count - CW'(1));
        end else if (i_dp_cmd.rd_parent) begin
            rd_addr_a = parent_addr;
        end else begin
            rd_addr_a = AW'(left_idx);
        end
        rd_addr_b = AW'(right_idx);
        rd_en     = i_dp_cmd.load_pop | i_dp_cmd.rd_parent | i_dp_cmd.rd_children;

        wr_en = i_dp_cmd.place | i_dp_cmd.move_up | i_dp_cmd.move_down;
        if (i_dp_cmd.move_up) begin
            wr_data = r_rd_a;
        end else if (i_dp_cmd.move_down) begin
            wr_data = sel_val;
        end else begin
            wr_data = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_hole] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= r_mem[rd_addr_a];
            r_rd_b <= r_mem[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_dp_cmd.load_push) begin
            r_count <= r_count + CW'(1);
        end else if (i_dp_cmd.load_pop) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load_push) begin
            r_val <= i_value;
        end else if (i_dp_cmd.take_last) begin
            r_val <= r_rd_a;
        end

        if (i_dp_cmd.load_push) begin
            r_hole <= AW'(r_count);
        end else if (i_dp_cmd.load_pop) begin
            r_hole <= '0;
        end else if (i_dp_cmd.move_up) begin
            r_hole <= parent_addr;
        end else if (i_dp_cmd.move_down) begin
            r_hole <= AW'(sel_idx);
        end

        if (wr_en && (r_hole == '0)) begin
            r_top <= wr_data;
        end

        if (i_dp_cmd.load_pop) begin
            r_removed <= r_top;
            r_status  <= ST_OK;
        end else if (i_dp_cmd.load_push) begin
            r_removed <= '0;
            r_status  <= ST_OK;
        end else if (i_dp_cmd.refuse_full) begin
            r_removed <= '0;
            r_status  <= ST_FULL;
        end else if (i_dp_cmd.refuse_empty) begin
            r_removed <= '0;
            r_status  <= ST_EMPTY;
        end
    end

    assign o_dp_sts.hole_root     = (r_hole == '0);
    assign o_dp_sts.has_child     = (left_idx < count_idx);
    assign o_dp_sts.parent_less   = (r_rd_a < r_val);
    assign o_dp_sts.child_greater = (r_val < sel_val);
    assign o_dp_sts.full          = (r_count == CW'(DEPTH));
    assign o_dp_sts.empty         = (r_count == '0);

    assign o_top_value     = (r_count != '0) ? r_top : '0;
    assign o_removed_value = r_removed;
    assign o_entry_count   = r_count;
    assign o_is_empty      = (r_count == '0);
    assign o_status        = r_status;

    `BMHQ_ASSERT_NEXT(a_push_count_step, i_clk, i_rst_n, i_dp_cmd.load_push, r_count == $past(r_count) + CW'(1))
    `BMHQ_ASSERT_SAME(a_move_up_not_root, i_clk, i_rst_n, i_dp_cmd.move_up, r_hole != '0)
    `BMHQ_ASSERT_SAME(a_move_down_in_range, i_clk, i_rst_n, i_dp_cmd.move_down, sel_idx < count_idx)

endmodule

>>> src/bmhq_ctrl.sv
// Controller state machine that sequences push and pop sifting in the heap datapath.
module bmhq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_cmd,
    input  bmhq_pkg::t_dp_sts i_dp_sts,
    output bmhq_pkg::t_dp_cmd o_dp_cmd,
    output logic              busy,
    output logic              o_valid
);
    import bmhq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_RD  = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_POP_LD = 3'd3;
    localparam logic [2:0] S_DN_RD  = 3'd4;
    localparam logic [2:0] S_DN_CMP = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_cmd == CMD_PUSH) begin
                        if (i_dp_sts.full) begin
                            o_dp_cmd.refuse_full = 1'b1;
                            n_state              = S_DONE;
                        end else begin
                            o_dp_cmd.load_push = 1'b1;
                            n_state            = S_UP_RD;
                        end
                    end else begin
                        if (i_dp_sts.empty) begin
                            o_dp_cmd.refuse_empty = 1'b1;
                            n_state               = S_DONE;
                        end else begin
                            o_dp_cmd.load_pop = 1'b1;
                            n_state           = S_POP_LD;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (i_dp_sts.hole_root) begin
                    o_dp_cmd.place = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_dp_cmd.rd_parent = 1'b1;
                    n_state            = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_dp_sts.parent_less) begin
                    o_dp_cmd.move_up = 1'b1;
                    n_state          = S_UP_RD;
                end else begin
                    o_dp_cmd.place = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_POP_LD: begin
                o_dp_cmd.take_last = 1'b1;
                n_state            = S_DN_RD;
            end
            S_DN_RD: begin
                if (i_dp_sts.has_child) begin
                    o_dp_cmd.rd_children = 1'b1;
                    n_state              = S_DN_CMP;
                end else begin
                    o_dp_cmd.place = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DN_CMP: begin
                if (i_dp_sts.child_greater) begin
                    o_dp_cmd.move_down = 1'b1;
                    n_state            = S_DN_RD;
                end else begin
                    o_dp_cmd.place = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

>>> src/binary_max_heap_queue_top.sv
// Top level of the binary max-heap priority queue of signed values.
// Usage: raise start with i_cmd and i_value; the item is taken at a rising edge where
// start is high and busy is low. i_cmd selects push of i_value or pop of the maximum.
// Exactly one result follows each item: o_valid is high for one cycle and the result
// ports then carry the maximum after the operation (zero when empty), the removed value
// of a successful pop, the entry count, the empty flag and the status (ok, push refused
// because full, pop refused because empty). The receiver cannot stall; results must be
// taken in the cycle they appear.
// Steps after acceptance: a push opens a hole at the new last slot and, level by
// level, reads the parent and moves it down while it is less than the value, then
// places the value; a pop moves the last entry to the root and, level by level, reads
// both children and moves the greater one up while it exceeds the entry, then places
// it. A push rises at most 6 levels at 64 entries and a pop sinks at most 5. Each
// level costs one registered memory read and one compare with write-back through the
// single write port of the heap memory. Refused operations go from acceptance straight
// to the result. busy stays high from acceptance through the result cycle, so one item
// is in work at a time and the next item can be taken only after busy falls again.
// Reset (synchronous, active low) empties the queue; memory contents are not cleared.
module binary_max_heap_queue_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_cmd,
    input  bmhq_pkg::t_value i_value,
    output logic             o_valid,
    output bmhq_pkg::t_value o_top_value,
    output bmhq_pkg::t_value o_removed_value,
    output bmhq_pkg::t_count o_entry_count,
    output logic             o_is_empty,
    output logic [1:0]       o_status
);
    import bmhq_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    bmhq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .i_dp_sts (dp_sts),
        .o_dp_cmd (dp_cmd),
        .busy     (busy),
        .o_valid  (o_valid)
    );

    bmhq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_value         (i_value),
        .i_dp_cmd        (dp_cmd),
        .o_dp_sts        (dp_sts),
        .o_top_value     (o_top_value),
        .o_removed_value (o_removed_value),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty),
        .o_status        (o_status)
    );

endmodule

>>> sim/tb_binary_max_heap_queue_top.sv
// Self-checking testbench of the binary max-heap queue with its own heap predictor.
module tb_binary_max_heap_queue_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bmhq_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        t_value     top_value;
        t_value     removed_value;
        t_count     entry_count;
        logic       is_empty;
        logic [1:0] status;
    } t_heap_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic       i_cmd = CMD_PUSH;
    t_value     i_value = '0;
    logic       o_valid;
    t_value     o_top_value;
    t_value     o_removed_value;
    t_count     o_entry_count;
    logic       o_is_empty;
    logic [1:0] o_status;

    t_value       heap_mirror [DEPTH];
    int           mirror_fill = 0;
    t_heap_result heap_results_due [$];
    int           fail_count = 0;
    int           stall_cycles = 0;
    int           burst_left = 0;
    bit           gaps_on = 1'b1;

    binary_max_heap_queue_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .o_top_value     (o_top_value),
        .o_removed_value (o_removed_value),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty),
        .o_status        (o_status)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_heap_result apply_heap_op(input logic cmd, input t_value value);
        t_heap_result res;
        int           node;
        int           parent;
        int           child;
        bit           done;
        t_value       tmp;
        res = '0;
        res.status = ST_OK;
        done = 1'b0;
        if (cmd == CMD_PUSH) begin
            if (mirror_fill >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                heap_mirror[mirror_fill] = value;
                node = mirror_fill;
                mirror_fill++;
                while (node > 0 && !done) begin
                    parent = (node - 1) / 2;
                    if (heap_mirror[parent] < heap_mirror[node]) begin
                        tmp = heap_mirror[parent];
                        heap_mirror[parent] = heap_mirror[node];
                        heap_mirror[node] = tmp;
                        node = parent;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
        end else begin
            if (mirror_fill == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.removed_value = heap_mirror[0];
                mirror_fill--;
                heap_mirror[0] = heap_mirror[mirror_fill];
                node = 0;
                while (2 * node + 1 < mirror_fill && !done) begin
                    child = 2 * node + 1;
                    if (child + 1 < mirror_fill && heap_mirror[child] < heap_mirror[child + 1]) begin
                        child++;
                    end
                    if (heap_mirror[node] < heap_mirror[child]) begin
                        tmp = heap_mirror[node];
                        heap_mirror[node] = heap_mirror[child];
                        heap_mirror[child] = tmp;
                        node = child;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
        end
        res.top_value   = (mirror_fill > 0) ? heap_mirror[0] : '0;
        res.entry_count = t_count'(mirror_fill);
        res.is_empty    = (mirror_fill == 0);
        return res;
    endfunction

    function automatic t_value pick_value();
        t_value v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
                    1: v = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
                    2: v = '0;
                    3: v = '1;
                    default: v = t_value'(1);
                endcase
            end
            1, 2, 3: v = t_value'($signed($urandom_range(0, 15)) - 8);
            default: v = t_value'($urandom);
        endcase
        return v;
    endfunction

    task automatic idle_for(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start   <= 1'b0;
            i_cmd   <= 1'($urandom);
            i_value <= t_value'($urandom);
        end
    endtask

    task automatic send_item(input logic cmd, input t_value value);
        int           gap;
        t_heap_result expected;
        @(negedge i_clk);
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected = apply_heap_op(cmd, value);
        heap_results_due = {heap_results_due, expected};
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 12);
                burst_left = $urandom_range(1, 20);
                idle_for(gap);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_for_results();
        idle_for(1);
        while (heap_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_edges();
        send_item(CMD_POP, t_value'($urandom));
        send_item(CMD_PUSH, {1'b0, {(VALUE_WIDTH-1){1'b1}}});
        send_item(CMD_PUSH, {1'b1, {(VALUE_WIDTH-1){1'b0}}});
        send_item(CMD_PUSH, '0);
        send_item(CMD_PUSH, '1);
        send_item(CMD_PUSH, t_value'(1));
        send_item(CMD_PUSH, {1'b0, {(VALUE_WIDTH-1){1'b1}}});
        send_item(CMD_PUSH, {1'b1, {(VALUE_WIDTH-1){1'b0}}});
        send_item(CMD_POP, '1);
        send_item(CMD_POP, '0);
        send_item(CMD_PUSH, t_value'(5));
        send_item(CMD_PUSH, t_value'(5));
        send_item(CMD_PUSH, t_value'(5));
        send_item(CMD_PUSH, t_value'(-5));
        while (mirror_fill > 0) send_item(CMD_POP, t_value'($urandom));
        send_item(CMD_POP, '1);
        wait_for_results();
    endtask

    task automatic test_full_queue();
        while (mirror_fill < DEPTH) send_item(CMD_PUSH, pick_value());
        send_item(CMD_PUSH, pick_value());
        send_item(CMD_PUSH, {1'b0, {(VALUE_WIDTH-1){1'b1}}});
        while (mirror_fill > 0) send_item(CMD_POP, t_value'($urandom));
        send_item(CMD_POP, t_value'($urandom));
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int push_pct;
        for (int round = 0; round < 14; round++) begin
            gaps_on = (round % 4 != 3);
            case (round % 5)
                0: push_pct = 85;
                1: push_pct = 15;
                default: push_pct = $urandom_range(35, 65);
            endcase
            repeat (110) begin
                if ($urandom_range(1, 100) <= push_pct) begin
                    send_item(CMD_PUSH, pick_value());
                end else begin
                    send_item(CMD_POP, t_value'($urandom));
                end
            end
        end
        gaps_on = 1'b1;
        wait_for_results();
    endtask

    always @(posedge i_clk) begin
        t_heap_result due;
        if (i_rst_n && o_valid) begin
            if (heap_results_due.size() == 0) begin
                $error("result with no item outstanding");
                fail_count++;
            end else begin
                due = heap_results_due.pop_front();
                if (o_top_value !== due.top_value) begin
                    $error("top_value expected %0d got %0d", due.top_value, o_top_value);
                    fail_count++;
                end
                if (o_removed_value !== due.removed_value) begin
                    $error("removed_value expected %0d got %0d",
                           due.removed_value, o_removed_value);
                    fail_count++;
                end
                if (o_entry_count !== due.entry_count) begin
                    $error("entry_count expected %0d got %0d", due.entry_count, o_entry_count);
                    fail_count++;
                end
                if (o_is_empty !== due.is_empty) begin
                    $error("is_empty expected %0d got %0d", due.is_empty, o_is_empty);
                    fail_count++;
                end
                if (o_status !== due.status) begin
                    $error("status expected %0d got %0d", due.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_edges();
        test_full_queue();
        test_random_traffic();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
